[rtl/core/pidpwm_pkg.sv]
// Shared widths, codes, reset values and types for the PID PWM drive.
package pidpwm_pkg;

    localparam int SPEED_W    = 24;
    localparam int ERR_W      = SPEED_W + 1;
    localparam int INT_W      = 20;
    localparam int DER_W      = ERR_W + 1;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 19;
    localparam int DUTY_W     = 8;
    localparam int FRAC_W     = 16;
    localparam int P_W        = GAIN_W + 1 + ERR_W;
    localparam int I_W        = GAIN_W + 1 + INT_W;
    localparam int D_W        = GAIN_W + 1 + DER_W;
    localparam int SUM_W      = D_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIM_W;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN  = 3'd5;

    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd307;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd77;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd13;
    localparam logic [LIM_W-1:0]  INT_LIMIT_RST = 19'd256000;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 8'd30;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_LOW   = 2'd1,
        ACT_HIGH  = 2'd2,
        ACT_CLEAR = 2'd3
    } act_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]  integral_limit;
        logic [DUTY_W-1:0] duty_max;
        logic [DUTY_W-1:0] duty_min;
    } cfg_t;

    typedef struct packed {
        logic silent;
        logic error_latched;
        logic fault_locked;
    } flags_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        flags_t                  flags;
    } diff_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
        flags_t                  flags;
    } terms_t;

    typedef struct packed {
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
        flags_t                flags;
    } prod_t;

endpackage

[rtl/core/pidpwm_if.sv]
// Channel interfaces: speed request, duty result and register write.
interface pidpwm_item_if;
    logic        valid;
    logic        ready;
    logic [23:0] target_speed;
    logic [23:0] measured_speed;
    logic        silent;
    logic        error_latched;
    logic        fault_locked;

    modport source (
        output valid, target_speed, measured_speed, silent, error_latched, fault_locked,
        input  ready
    );
    modport sink (
        input  valid, target_speed, measured_speed, silent, error_latched, fault_locked,
        output ready
    );
endinterface

interface pidpwm_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty;
    logic [1:0] error_action;

    modport source (output valid, duty, error_action, input ready);
    modport sink (input valid, duty, error_action, output ready);
endinterface

interface pidpwm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [18:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/pidpwm_cfg.sv]
// Configuration register file: gains, integral clamp and duty limits.
module pidpwm_cfg (
    input  logic               clk,
    input  logic               rst_n,
    pidpwm_cfg_if.sink         cfg_wr,
    output pidpwm_pkg::cfg_t   cfg
);

    pidpwm_pkg::cfg_t cfg_reg;

    assign cfg_wr.ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= pidpwm_pkg::GAIN_P_RST;
            cfg_reg.gain_i         <= pidpwm_pkg::GAIN_I_RST;
            cfg_reg.gain_d         <= pidpwm_pkg::GAIN_D_RST;
            cfg_reg.integral_limit <= pidpwm_pkg::INT_LIMIT_RST;
            cfg_reg.duty_max       <= pidpwm_pkg::DUTY_MAX_RST;
            cfg_reg.duty_min       <= pidpwm_pkg::DUTY_MIN_RST;
        end
        else if (cfg_wr.valid)
        begin
            case (cfg_wr.index)
                pidpwm_pkg::CFG_GAIN_P:
                    cfg_reg.gain_p <= cfg_wr.data[pidpwm_pkg::GAIN_W-1:0];
                pidpwm_pkg::CFG_GAIN_I:
                    cfg_reg.gain_i <= cfg_wr.data[pidpwm_pkg::GAIN_W-1:0];
                pidpwm_pkg::CFG_GAIN_D:
                    cfg_reg.gain_d <= cfg_wr.data[pidpwm_pkg::GAIN_W-1:0];
                pidpwm_pkg::CFG_INT_LIMIT:
                    cfg_reg.integral_limit <= cfg_wr.data[pidpwm_pkg::LIM_W-1:0];
                pidpwm_pkg::CFG_DUTY_MAX:
                    cfg_reg.duty_max <= cfg_wr.data[pidpwm_pkg::DUTY_W-1:0];
                pidpwm_pkg::CFG_DUTY_MIN:
                    cfg_reg.duty_min <= cfg_wr.data[pidpwm_pkg::DUTY_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[rtl/core/pidpwm_err.sv]
// Error capture, clamped integral and derivative, with the controller state.
module pidpwm_err (
    input  logic                  clk,
    input  logic                  rst_n,
    pidpwm_item_if.sink           item,
    input  pidpwm_pkg::cfg_t      cfg,
    output logic                  terms_valid,
    input  logic                  terms_ready,
    output pidpwm_pkg::terms_t    terms
);

    localparam int RAW_W = pidpwm_pkg::ERR_W + 1;

    logic                                   s1_valid_reg;
    pidpwm_pkg::diff_t                      s1_reg;
    pidpwm_pkg::diff_t                      s1_next;
    logic                                   s2_valid_reg;
    pidpwm_pkg::terms_t                     s2_reg;
    pidpwm_pkg::terms_t                     s2_next;
    logic signed [pidpwm_pkg::INT_W-1:0]    integral_reg;
    logic signed [pidpwm_pkg::INT_W-1:0]    integral_next;
    logic signed [pidpwm_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [RAW_W-1:0]                integ_raw;
    logic signed [RAW_W-1:0]                lim_pos;
    logic signed [RAW_W-1:0]                lim_neg;
    logic                                   s1_ready;
    logic                                   s2_ready;
    logic                                   s2_load;

    assign s2_ready    = !s2_valid_reg || terms_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign s2_load     = s1_valid_reg && s2_ready;
    assign item.ready  = s1_ready;
    assign terms_valid = s2_valid_reg;
    assign terms       = s2_reg;

    always_comb
    begin
        s1_next.err = $signed({1'b0, item.target_speed}) - $signed({1'b0, item.measured_speed});
        s1_next.flags.silent        = item.silent;
        s1_next.flags.error_latched = item.error_latched;
        s1_next.flags.fault_locked  = item.fault_locked;
    end

    // integral: add, then clamp to the symmetric limit
    always_comb
    begin
        integ_raw = RAW_W'(integral_reg) + RAW_W'(s1_reg.err);
        lim_pos   = $signed(RAW_W'(cfg.integral_limit));
        lim_neg   = -lim_pos;
        if (integ_raw > lim_pos)
            integral_next = pidpwm_pkg::INT_W'(lim_pos);
        else if (integ_raw < lim_neg)
            integral_next = pidpwm_pkg::INT_W'(lim_neg);
        else
            integral_next = pidpwm_pkg::INT_W'(integ_raw);

        s2_next.err   = s1_reg.err;
        s2_next.integ = integral_next;
        s2_next.deriv = pidpwm_pkg::DER_W'(s1_reg.err) - pidpwm_pkg::DER_W'(prev_err_reg);
        s2_next.flags = s1_reg.flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            integral_reg <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= item.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s2_load)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= s1_reg.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && s1_ready)
            s1_reg <= s1_next;
        if (s2_load)
            s2_reg <= s2_next;
    end

    // the state always reflects the request held in the second stage
    a_prev_err_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> prev_err_reg == s2_reg.err)
        else $error("previous error does not match staged request");

    a_integral_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> integral_reg == s2_reg.integ)
        else $error("integral state does not match staged request");

endmodule

[rtl/core/pidpwm_mul.sv]
// Gain multiply stage: three Q8.8 gain products, registered.
module pidpwm_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidpwm_pkg::cfg_t      cfg,
    input  logic                  terms_valid,
    output logic                  terms_ready,
    input  pidpwm_pkg::terms_t    terms,
    output logic                  prod_valid,
    input  logic                  prod_ready,
    output pidpwm_pkg::prod_t     prod
);

    logic                 prod_valid_reg;
    pidpwm_pkg::prod_t    prod_reg;
    pidpwm_pkg::prod_t    prod_next;

    assign terms_ready = !prod_valid_reg || prod_ready;
    assign prod_valid  = prod_valid_reg;
    assign prod        = prod_reg;

    always_comb
    begin
        prod_next.p_term = pidpwm_pkg::P_W'($signed({1'b0, cfg.gain_p}))
                         * pidpwm_pkg::P_W'(terms.err);
        prod_next.i_term = pidpwm_pkg::I_W'($signed({1'b0, cfg.gain_i}))
                         * pidpwm_pkg::I_W'(terms.integ);
        prod_next.d_term = pidpwm_pkg::D_W'($signed({1'b0, cfg.gain_d}))
                         * pidpwm_pkg::D_W'(terms.deriv);
        prod_next.flags  = terms.flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (terms_ready)
            prod_valid_reg <= terms_valid;
    end

    always_ff @(posedge clk)
    begin
        if (terms_valid && terms_ready)
            prod_reg <= prod_next;
    end

endmodule

[rtl/core/pidpwm_sat.sv]
// PID sum, duty clamp with deadband floor, error action and result register.
module pidpwm_sat (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pidpwm_pkg::cfg_t      cfg,
    input  logic                  prod_valid,
    output logic                  prod_ready,
    input  pidpwm_pkg::prod_t     prod,
    pidpwm_result_if.source       result
);

    localparam int SUM_W = pidpwm_pkg::SUM_W;

    logic                                   sum_valid_reg;
    logic signed [SUM_W-1:0]                sum_reg;
    pidpwm_pkg::flags_t                     flags_reg;
    logic                                   out_valid_reg;
    logic [pidpwm_pkg::DUTY_W-1:0]          duty_reg;
    logic [pidpwm_pkg::DUTY_W-1:0]          duty_next;
    pidpwm_pkg::act_t                       act_reg;
    pidpwm_pkg::act_t                       act_next;
    logic                                   sum_ready;
    logic                                   out_ready;
    logic                                   out_load;
    logic signed [SUM_W-1:0]                hi;
    logic signed [SUM_W-1:0]                lo;
    logic signed [SUM_W-1:0]                clip;
    logic signed [SUM_W-1:0]                fin;
    logic                                   pos;
    logic                                   over;
    logic                                   low;
    logic                                   allow;
    logic                                   latched;

    assign out_ready  = !out_valid_reg || result.ready;
    assign sum_ready  = !sum_valid_reg || out_ready;
    assign out_load   = sum_valid_reg && out_ready;
    assign prod_ready = sum_ready;

    assign result.valid        = out_valid_reg;
    assign result.duty         = duty_reg;
    assign result.error_action = act_reg;

    always_comb
    begin
        hi    = $signed(SUM_W'({cfg.duty_max, {pidpwm_pkg::FRAC_W{1'b0}}}));
        lo    = $signed(SUM_W'({cfg.duty_min, {pidpwm_pkg::FRAC_W{1'b0}}}));
        pos   = !sum_reg[SUM_W-1] && (sum_reg != '0);
        over  = pos && (sum_reg > hi);
        clip  = over ? hi : sum_reg;
        // a high clamp to zero leaves nothing to floor
        low   = pos && (over ? (cfg.duty_max != '0) : 1'b1) && (clip < lo);
        fin   = !pos ? '0 : (low ? lo : clip);
        allow = !flags_reg.silent && !flags_reg.error_latched && !flags_reg.fault_locked;
        latched = flags_reg.error_latched || (over && allow);

        act_next = pidpwm_pkg::ACT_NONE;
        if (over && allow)
            act_next = pidpwm_pkg::ACT_HIGH;
        if (low && !flags_reg.silent && !latched && !flags_reg.fault_locked)
            act_next = pidpwm_pkg::ACT_LOW;
        if (!flags_reg.silent && !flags_reg.fault_locked && (fin > lo) && (fin < hi))
            act_next = pidpwm_pkg::ACT_CLEAR;

        duty_next = fin[pidpwm_pkg::FRAC_W +: pidpwm_pkg::DUTY_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_ready)
                sum_valid_reg <= prod_valid;
            if (out_ready)
                out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid && sum_ready)
        begin
            sum_reg   <= SUM_W'(prod.p_term) + SUM_W'(prod.i_term) + SUM_W'(prod.d_term);
            flags_reg <= prod.flags;
        end
        if (out_load)
        begin
            duty_reg <= duty_next;
            act_reg  <= act_next;
        end
    end

    a_high_needs_allow: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && act_next == pidpwm_pkg::ACT_HIGH
        |-> !flags_reg.silent && !flags_reg.error_latched && !flags_reg.fault_locked)
        else $error("high raise issued while blocked");

    a_low_at_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && act_next == pidpwm_pkg::ACT_LOW |-> duty_next == cfg.duty_min)
        else $error("low raise without duty at floor");

    a_clear_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && act_next == pidpwm_pkg::ACT_CLEAR
        |-> duty_next >= cfg.duty_min && duty_next <= cfg.duty_max)
        else $error("clear issued with duty outside band");

endmodule

[rtl/core/pid_pwm_drive_with_deadband.sv]
// PID speed controller driving an 8-bit PWM duty with integral clamp and deadband floor.
//
// Each request carries a target and a measured shaft speed (1/256 rpm) plus
// three status flags; each produces exactly one result holding the PWM duty
// and an error action (none, raise low, raise high, clear). The block takes
// one request per clock unless result back-pressure stalls the stages. A
// request passes through five register stages: error capture,
// integral/derivative update, gain multiply, PID sum, then duty clamp into
// the result register, from which the result is presented.
// Every stage has its own valid bit and ready, so requests keep filling empty
// stages while a result waits at the output. The integral and previous-error
// state advance in the integral/derivative stage, so consecutive requests see
// each other's state with no gap. Registers (gains Q8.8, integral limit,
// duty max/min) are written through the cfg channel, which is always ready;
// write them only while no request is in flight.
module pid_pwm_drive_with_deadband (
    input  logic              clk,
    input  logic              rst_n,
    pidpwm_item_if.sink       item,
    pidpwm_result_if.source   result,
    pidpwm_cfg_if.sink        cfg
);

    pidpwm_pkg::cfg_t     cfg_regs;
    logic                 terms_valid;
    logic                 terms_ready;
    pidpwm_pkg::terms_t   terms;
    logic                 prod_valid;
    logic                 prod_ready;
    pidpwm_pkg::prod_t    prod;

    // register file
    pidpwm_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg),
        .cfg    (cfg_regs)
    );

    // error, clamped integral, derivative; owns the loop state
    pidpwm_err u_err (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .cfg         (cfg_regs),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms)
    );

    // three gain products
    pidpwm_mul u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_regs),
        .terms_valid (terms_valid),
        .terms_ready (terms_ready),
        .terms       (terms),
        .prod_valid  (prod_valid),
        .prod_ready  (prod_ready),
        .prod        (prod)
    );

    // sum, clamp, action decode, result register
    pidpwm_sat u_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_regs),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod       (prod),
        .result     (result)
    );

endmodule
